### rtl/core/stt_pkg.sv
// Shared types, constants and character-class functions for the source text tokenizer.
`default_nettype none

package stt_pkg;

    localparam int LINE_BITS_DEF   = 20;
    localparam int COLUMN_BITS_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;
    localparam int KIND_BITS       = 5;
    localparam int LEN_BITS        = 16;
    localparam int CFG_BITS        = 16;
    localparam int IDX_BITS        = 3;
    localparam int MAX_RESULTS     = 3;
    // power of two, at least 4
    localparam int FIFO_DEPTH      = 8;

    typedef enum logic [3:0] {
        M_IDLE, M_DONE, M_STR, M_CMT_A, M_CMT_B, M_CLOSE2, M_SYM, M_ALPHA,
        M_INT, M_FRAC, M_EXPS, M_EXP, M_HEX_X, M_HEX
    } t_mode;

    localparam logic [KIND_BITS-1:0] K_END     = 5'd0;
    localparam logic [KIND_BITS-1:0] K_ALPHA   = 5'd1;
    localparam logic [KIND_BITS-1:0] K_SYM     = 5'd2;
    localparam logic [KIND_BITS-1:0] K_COMMENT = 5'd3;
    localparam logic [KIND_BITS-1:0] K_INT     = 5'd4;
    localparam logic [KIND_BITS-1:0] K_FLOAT   = 5'd5;
    localparam logic [KIND_BITS-1:0] K_STRING  = 5'd6;
    localparam logic [KIND_BITS-1:0] K_CHAR    = 5'd7;
    localparam logic [KIND_BITS-1:0] K_DOT     = 5'd8;
    localparam logic [KIND_BITS-1:0] K_COMMA   = 5'd9;
    localparam logic [KIND_BITS-1:0] K_SEMI    = 5'd10;
    localparam logic [KIND_BITS-1:0] K_LPAREN  = 5'd11;
    localparam logic [KIND_BITS-1:0] K_RPAREN  = 5'd12;
    localparam logic [KIND_BITS-1:0] K_LBRACK  = 5'd13;
    localparam logic [KIND_BITS-1:0] K_RBRACK  = 5'd14;
    localparam logic [KIND_BITS-1:0] K_LBRACE  = 5'd15;
    localparam logic [KIND_BITS-1:0] K_RBRACE  = 5'd16;

    localparam logic [IDX_BITS-1:0] REG_CMT_OPEN  = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_CMT_CLOSE = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_ALT_OPEN  = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_ALT_CLOSE = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_HIDE      = 3'd4;

    localparam logic [CFG_BITS-1:0] CMT_OPEN_RST  = 16'd12079;
    localparam logic [CFG_BITS-1:0] CMT_CLOSE_RST = 16'd10;
    localparam logic [CFG_BITS-1:0] ALT_OPEN_RST  = 16'd10799;
    localparam logic [CFG_BITS-1:0] ALT_CLOSE_RST = 16'd12074;
    localparam logic                HIDE_RST      = 1'b1;

    typedef struct packed {
        logic [CFG_BITS-1:0] cmt_open;
        logic [CFG_BITS-1:0] cmt_close;
        logic [CFG_BITS-1:0] alt_open;
        logic [CFG_BITS-1:0] alt_close;
        logic                hide;
    } t_cfg;

    function automatic logic is_space(input logic [7:0] c);
        return c inside {[8'h09:8'h0D], 8'h20};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"]};
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_letter(c) || is_digit(c) || (c == "_");
    endfunction

    function automatic logic is_xdigit(input logic [7:0] c);
        return c inside {["0":"9"], ["a":"f"], ["A":"F"]};
    endfunction

    function automatic logic is_expo(input logic [7:0] c);
        return (c == "e") || (c == "E");
    endfunction

    function automatic logic is_symbolic(input logic [7:0] c);
        return c inside {"+", "-", "*", "/", "\\", "<", "=", ">", "~", "!", "@", "#",
                         "$", "%", "^", "&", "|", ":"};
    endfunction

    // K_END when c is no punctuation
    function automatic logic [KIND_BITS-1:0] punct_kind(input logic [7:0] c);
        logic [KIND_BITS-1:0] k;
        case (c)
            ".":     k = K_DOT;
            ",":     k = K_COMMA;
            ";":     k = K_SEMI;
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "[":     k = K_LBRACK;
            "]":     k = K_RBRACK;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            default: k = K_END;
        endcase
        return k;
    endfunction

    // low byte first char, high byte second char or zero for a one-char delimiter
    function automatic logic delim_hit(input logic [CFG_BITS-1:0] dreg, input logic [7:0] c,
                                       input logic [7:0] n, input logic nv);
        return (c == dreg[7:0]) && ((dreg[15:8] == 8'h00) || (nv && (n == dreg[15:8])));
    endfunction

    // does the token in mode m continue with next char n
    function automatic logic accepts(input t_mode m, input logic [7:0] n);
        logic a;
        case (m)
            M_STR, M_CMT_A, M_CMT_B, M_CLOSE2: a = 1'b1;
            M_SYM:   a = is_symbolic(n);
            M_ALPHA: a = is_word(n);
            M_INT:   a = is_digit(n) || (n == "_") || (n == ".") || is_expo(n);
            M_FRAC:  a = is_digit(n) || (n == "_") || is_expo(n);
            M_EXPS:  a = is_digit(n) || (n == "+") || (n == "-");
            M_EXP:   a = is_digit(n);
            M_HEX_X: a = (n == "x");
            M_HEX:   a = is_xdigit(n);
            default: a = 1'b0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

### rtl/core/stt_scan.sv
// Scanner state and combinational step: held lookahead char, mode, position counters.
`default_nettype none

module stt_scan #(
    parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = stt_pkg::COLUMN_BITS_DEF,
    parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                                                    i_clk,
    input  wire logic                                                    i_rst_n,
    input  wire logic                                                    i_take,
    input  wire logic [7:0]                                              i_char_code,
    input  wire logic                                                    i_end_of_stream,
    input  wire stt_pkg::t_cfg                                           i_cfg,
    output logic [stt_pkg::MAX_RESULTS-1:0]                              o_push,
    output logic [stt_pkg::MAX_RESULTS-1:0][stt_pkg::KIND_BITS-1:0]      o_kind,
    output logic [stt_pkg::MAX_RESULTS-1:0][LINE_BITS-1:0]               o_line,
    output logic [stt_pkg::MAX_RESULTS-1:0][COLUMN_BITS-1:0]             o_column,
    output logic [stt_pkg::MAX_RESULTS-1:0][stt_pkg::LEN_BITS-1:0]       o_length,
    output logic [stt_pkg::MAX_RESULTS-1:0][OFFSET_BITS-1:0]             o_offset,
    output logic [stt_pkg::MAX_RESULTS-1:0]                              o_run_end
);

    localparam logic [LINE_BITS-1:0]        LINE_MAX = '1;
    localparam logic [COLUMN_BITS-1:0]      COL_MAX  = '1;
    localparam logic [OFFSET_BITS-1:0]      OFF_MAX  = '1;
    localparam logic [stt_pkg::LEN_BITS-1:0] LEN_MAX = '1;

    typedef struct packed {
        stt_pkg::t_mode                  mode;
        logic [stt_pkg::KIND_BITS-1:0]   kind;
        logic [7:0]                      prior;
        logic [OFFSET_BITS-1:0]          off;
        logic [LINE_BITS-1:0]            line;
        logic [COLUMN_BITS-1:0]          col;
        logic [OFFSET_BITS-1:0]          s_off;
        logic [LINE_BITS-1:0]            s_line;
        logic [COLUMN_BITS-1:0]          s_col;
        logic [stt_pkg::LEN_BITS-1:0]    len;
    } t_scan_st;

    function automatic logic [LINE_BITS-1:0] line_now(input logic [LINE_BITS-1:0] l);
        return (l != LINE_MAX) ? l + LINE_BITS'(1) : LINE_MAX;
    endfunction

    function automatic logic [COLUMN_BITS-1:0] col_now(input logic [COLUMN_BITS-1:0] c);
        return (c != COL_MAX) ? c + COLUMN_BITS'(1) : COL_MAX;
    endfunction

    function automatic t_scan_st count_char(input t_scan_st s, input logic [7:0] c);
        t_scan_st t;
        t = s;
        if (t.off != OFF_MAX) begin
            t.off = t.off + OFFSET_BITS'(1);
        end
        if (c == 8'h0A) begin
            if (t.line != LINE_MAX) begin
                t.line = t.line + LINE_BITS'(1);
            end
            t.col = '0;
        end else if (t.col != COL_MAX) begin
            t.col = t.col + COLUMN_BITS'(1);
        end
        return t;
    endfunction

    // scan char c with lookahead n (valid when nv)
    function automatic t_scan_st scan_char(input t_scan_st s, input logic [7:0] c,
                                           input logic [7:0] n, input logic nv,
                                           input stt_pkg::t_cfg cfg, output logic emit);
        t_scan_st                      t;
        logic [stt_pkg::CFG_BITS-1:0]  creg;
        logic [7:0]                    quote;
        logic [stt_pkg::KIND_BITS-1:0] pk;
        t     = s;
        emit  = 1'b0;
        creg  = (s.mode == stt_pkg::M_CMT_A) ? cfg.cmt_close : cfg.alt_close;
        quote = (s.kind == stt_pkg::K_STRING) ? 8'h22 : 8'h27;
        pk    = stt_pkg::punct_kind(c);
        if ((s.mode == stt_pkg::M_IDLE) && stt_pkg::is_space(c)) begin
            t.prior = c;
            t = count_char(t, c);
        end else begin
            if (s.mode == stt_pkg::M_IDLE) begin
                t.s_off  = s.off;
                t.s_line = line_now(s.line);
                t.s_col  = col_now(s.col);
                t.len    = '0;
                if (c == 8'h22) begin
                    t.kind = stt_pkg::K_STRING;
                    t.mode = stt_pkg::M_STR;
                end else if (c == 8'h27) begin
                    t.kind = stt_pkg::K_CHAR;
                    t.mode = stt_pkg::M_STR;
                end else if (stt_pkg::delim_hit(cfg.cmt_open, c, n, nv)) begin
                    t.kind = stt_pkg::K_COMMENT;
                    t.mode = stt_pkg::M_CMT_A;
                end else if (stt_pkg::delim_hit(cfg.alt_open, c, n, nv)) begin
                    t.kind = stt_pkg::K_COMMENT;
                    t.mode = stt_pkg::M_CMT_B;
                end else if (pk != stt_pkg::K_END) begin
                    t.kind = pk;
                    t.mode = stt_pkg::M_DONE;
                end else if (stt_pkg::is_digit(c)) begin
                    t.kind = stt_pkg::K_INT;
                    t.mode = ((c == "0") && nv && (n == "x")) ? stt_pkg::M_HEX_X
                                                              : stt_pkg::M_INT;
                end else if (stt_pkg::is_symbolic(c)) begin
                    t.kind = stt_pkg::K_SYM;
                    t.mode = stt_pkg::M_SYM;
                end else begin
                    t.kind = stt_pkg::K_ALPHA;
                    t.mode = (stt_pkg::is_letter(c) || (c == "_")) ? stt_pkg::M_ALPHA
                                                                   : stt_pkg::M_DONE;
                end
            end else begin
                case (s.mode)
                    stt_pkg::M_STR: begin
                        if ((c == quote) && (s.prior != 8'h5C)) begin
                            t.mode = stt_pkg::M_DONE;
                        end
                    end
                    stt_pkg::M_CMT_A, stt_pkg::M_CMT_B: begin
                        if (c == creg[7:0]) begin
                            if (creg[15:8] == 8'h00) begin
                                t.mode = stt_pkg::M_DONE;
                            end else if (nv && (n == creg[15:8])) begin
                                t.mode = stt_pkg::M_CLOSE2;
                            end
                        end
                    end
                    stt_pkg::M_CLOSE2: t.mode = stt_pkg::M_DONE;
                    stt_pkg::M_INT: begin
                        if (c == ".") begin
                            t.kind = stt_pkg::K_FLOAT;
                            t.mode = stt_pkg::M_FRAC;
                        end else if (stt_pkg::is_expo(c)) begin
                            t.kind = stt_pkg::K_FLOAT;
                            t.mode = stt_pkg::M_EXPS;
                        end
                    end
                    stt_pkg::M_FRAC: begin
                        if (stt_pkg::is_expo(c)) begin
                            t.mode = stt_pkg::M_EXPS;
                        end
                    end
                    stt_pkg::M_EXPS:  t.mode = stt_pkg::M_EXP;
                    stt_pkg::M_HEX_X: t.mode = stt_pkg::M_HEX;
                    default:          t.mode = s.mode;
                endcase
            end
            if (t.len != LEN_MAX) begin
                t.len = t.len + stt_pkg::LEN_BITS'(1);
            end
            t.prior = c;
            t = count_char(t, c);
            if (!nv || !stt_pkg::accepts(t.mode, n)) begin
                emit   = !((t.kind == stt_pkg::K_COMMENT) && cfg.hide);
                t.mode = stt_pkg::M_IDLE;
            end
        end
        return t;
    endfunction

    t_scan_st   r_st, n_st;
    logic [7:0] r_held, n_held;
    logic       r_held_valid, n_held_valid;

    t_scan_st   w_s1, w_s2;
    logic       w_v1, w_v2;

    // held char scanned against the new char, then the new char itself at end of text
    always_comb begin
        w_s1 = r_st;
        w_v1 = 1'b0;
        if (r_held_valid) begin
            w_s1 = scan_char(r_st, r_held, i_char_code, 1'b1, i_cfg, w_v1);
        end
        w_s2 = scan_char(w_s1, i_char_code, 8'h00, 1'b0, i_cfg, w_v2);
    end

    always_comb begin
        if (i_end_of_stream) begin
            n_st         = '0;
            n_held       = 8'h00;
            n_held_valid = 1'b0;
        end else begin
            n_st         = w_s1;
            n_held       = i_char_code;
            n_held_valid = 1'b1;
        end
    end

    always_comb begin
        o_push[0]    = i_take && w_v1;
        o_kind[0]    = w_s1.kind;
        o_line[0]    = w_s1.s_line;
        o_column[0]  = w_s1.s_col;
        o_length[0]  = w_s1.len;
        o_offset[0]  = w_s1.s_off;
        o_run_end[0] = !i_end_of_stream;

        o_push[1]    = i_take && i_end_of_stream && w_v2;
        o_kind[1]    = w_s2.kind;
        o_line[1]    = w_s2.s_line;
        o_column[1]  = w_s2.s_col;
        o_length[1]  = w_s2.len;
        o_offset[1]  = w_s2.s_off;
        o_run_end[1] = 1'b0;

        o_push[2]    = i_take && i_end_of_stream;
        o_kind[2]    = stt_pkg::K_END;
        o_line[2]    = line_now(w_s2.line);
        o_column[2]  = col_now(w_s2.col);
        o_length[2]  = stt_pkg::LEN_BITS'(1);
        o_offset[2]  = w_s2.off;
        o_run_end[2] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st         <= '0;
            r_held       <= 8'h00;
            r_held_valid <= 1'b0;
        end else if (i_take) begin
            r_st         <= n_st;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
        end
    end

endmodule

`default_nettype wire

### rtl/core/stt_fifo.sv
// Result queue: up to LANES pushes per cycle, one pop per cycle.
`default_nettype none

module stt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = stt_pkg::FIFO_DEPTH,
    parameter int LANES = stt_pkg::MAX_RESULTS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [LANES-1:0]            i_push,
    input  wire logic [LANES-1:0][WIDTH-1:0] i_data,
    output logic                             o_space,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [WIDTH-1:0]                 o_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;

    logic [WIDTH-1:0]          r_mem [DEPTH];
    logic [AW-1:0]             r_wptr, n_wptr;
    logic [AW-1:0]             r_rptr;
    logic [CW-1:0]             r_count, n_count;
    logic [LANES-1:0][AW-1:0]  w_idx;
    logic [CW-1:0]             w_npush;
    logic                      w_pop;

    assign o_valid = (r_count != '0);
    assign o_space = (r_count <= CW'(DEPTH - LANES));
    assign o_data  = r_mem[r_rptr];
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wptr  = r_wptr;
        w_npush = '0;
        for (int i = 0; i < LANES; i++) begin
            w_idx[i] = n_wptr;
            n_wptr   = n_wptr + AW'(i_push[i]);
            w_npush  = w_npush + CW'(i_push[i]);
        end
        n_count = r_count + w_npush - CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < LANES; i++) begin
            if (i_push[i]) begin
                r_mem[w_idx[i]] <= i_data[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_count <= n_count;
            if (w_pop) begin
                r_rptr <= r_rptr + AW'(1);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/source_text_tokenizer_top.sv
// Source text tokenizer top level: config registers, scanner and result queue.
//
// Usage:
//  - Input channel (i_valid/o_ready): one source byte per transfer; i_end_of_stream
//    marks the last byte of a text. Each byte is held as lookahead; the byte before
//    it is scanned when it arrives, so a token is finished one byte late.
//  - Output channel (o_valid/i_ready): one token per transfer, in order. One input
//    transfer yields 0 to 3 tokens; o_run_end flags the last one of that transfer.
//    The final byte of a text yields its pending token(s) plus an end token.
//  - Config channel (i_cfg_valid/o_cfg_ready): register index and data, always
//    ready; write only while no transfer is in flight.
//  - Tokens of an input transfer are registered into the queue behind earlier ones.
//  - Throughput: one byte per cycle; the 8-entry result queue accepts a byte only
//    while it has room for 3 tokens, so a stalled receiver backs up the input once
//    the queue fills. Only a final byte can yield 2-3 tokens, drained at one per cycle.
//  - Reset: scanner restarts at offset 0, line 1, column 1, queue empties and the
//    config registers return to their defaults. End of text restarts the scanner
//    the same way but keeps the config and the queue contents.
`default_nettype none

module source_text_tokenizer_top #(
    parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = stt_pkg::COLUMN_BITS_DEF,
    parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,

    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [7:0]                      i_char_code,
    input  wire logic                            i_end_of_stream,

    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [stt_pkg::KIND_BITS-1:0]        o_token_kind,
    output logic [LINE_BITS-1:0]                 o_token_line,
    output logic [COLUMN_BITS-1:0]               o_token_column,
    output logic [stt_pkg::LEN_BITS-1:0]         o_token_length,
    output logic [OFFSET_BITS-1:0]               o_token_offset,
    output logic                                 o_run_end,

    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [stt_pkg::IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [stt_pkg::CFG_BITS-1:0]    i_cfg_data
);

    localparam int LANES = stt_pkg::MAX_RESULTS;

    typedef struct packed {
        logic [stt_pkg::KIND_BITS-1:0] kind;
        logic [LINE_BITS-1:0]          line;
        logic [COLUMN_BITS-1:0]        col;
        logic [stt_pkg::LEN_BITS-1:0]  len;
        logic [OFFSET_BITS-1:0]        off;
        logic                          run_end;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    stt_pkg::t_cfg                                   r_cfg;
    logic                                            w_take;
    logic [LANES-1:0]                                w_push;
    logic [LANES-1:0][stt_pkg::KIND_BITS-1:0]        w_kind;
    logic [LANES-1:0][LINE_BITS-1:0]                 w_line;
    logic [LANES-1:0][COLUMN_BITS-1:0]               w_col;
    logic [LANES-1:0][stt_pkg::LEN_BITS-1:0]         w_len;
    logic [LANES-1:0][OFFSET_BITS-1:0]               w_off;
    logic [LANES-1:0]                                w_run_end;
    logic [LANES-1:0][ENTRY_W-1:0]                   w_lane_data;
    logic [ENTRY_W-1:0]                              w_head_bits;
    t_entry                                          w_head;

    assign o_cfg_ready = 1'b1;
    assign w_take      = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cmt_open  <= stt_pkg::CMT_OPEN_RST;
            r_cfg.cmt_close <= stt_pkg::CMT_CLOSE_RST;
            r_cfg.alt_open  <= stt_pkg::ALT_OPEN_RST;
            r_cfg.alt_close <= stt_pkg::ALT_CLOSE_RST;
            r_cfg.hide      <= stt_pkg::HIDE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                stt_pkg::REG_CMT_OPEN:  r_cfg.cmt_open  <= i_cfg_data;
                stt_pkg::REG_CMT_CLOSE: r_cfg.cmt_close <= i_cfg_data;
                stt_pkg::REG_ALT_OPEN:  r_cfg.alt_open  <= i_cfg_data;
                stt_pkg::REG_ALT_CLOSE: r_cfg.alt_close <= i_cfg_data;
                stt_pkg::REG_HIDE:      r_cfg.hide      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    stt_scan #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (w_take),
        .i_char_code     (i_char_code),
        .i_end_of_stream (i_end_of_stream),
        .i_cfg           (r_cfg),
        .o_push          (w_push),
        .o_kind          (w_kind),
        .o_line          (w_line),
        .o_column        (w_col),
        .o_length        (w_len),
        .o_offset        (w_off),
        .o_run_end       (w_run_end)
    );

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            w_lane_data[i] = {w_kind[i], w_line[i], w_col[i], w_len[i], w_off[i],
                              w_run_end[i]};
        end
    end

    stt_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (stt_pkg::FIFO_DEPTH),
        .LANES (LANES)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_lane_data),
        .o_space (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (w_head_bits)
    );

    assign w_head         = w_head_bits;
    assign o_token_kind   = w_head.kind;
    assign o_token_line   = w_head.line;
    assign o_token_column = w_head.col;
    assign o_token_length = w_head.len;
    assign o_token_offset = w_head.off;
    assign o_run_end      = w_head.run_end;

    a_end_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_end_of_stream) |-> w_push[2])
        else $error("end of text without end token");

    a_push_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push != '0) |-> w_take)
        else $error("token pushed without input transfer");

    a_lane_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push[1] |-> w_push[2])
        else $error("last-byte token without end token");

    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_ready) |-> $past(w_push != '0))
        else $error("input stalled without queue growth");

endmodule

`default_nettype wire
